// ===== rtl/core/slid_pkg.sv =====
// shared types and codes for the sorted list block
`timescale 1ns / 1ps

package slid_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DELETE    = 2'd1,
    OP_DUMP_ASC  = 2'd2,
    OP_DUMP_DESC = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROT_LEFT,
    CMD_ROT_RIGHT
  } cell_cmd_e;

  typedef struct packed {
    op_e                      op;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] out_value;
    status_e                  status;
    logic                     last_of_run;
  } out_item_t;

  typedef struct packed {
    cell_cmd_e                cmd;
    logic signed [ValueW-1:0] operand;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sorted_list_insert_delete_top.sv =====
// top level of the sorted list: control, fill count and the cell chain
`timescale 1ns / 1ps

// Keeps up to Capacity signed 32-bit values in ascending order in a chain of
// cells. Insert and delete compare in every cell at once and shift the chain
// together, so one such transfer can be taken each cycle unless the output
// stalls, and each gives one result. A dump of n entries latches its length,
// then hands out one entry per cycle unless the output stalls, the chain
// rotating by one place per entry; no new item is taken until the last entry
// has left. An empty dump gives one list-empty result at once. An output
// register decouples the result side; an output stall holds the whole block.
module sorted_list_insert_delete_top #(
  parameter int unsigned Capacity = slid_pkg::DefaultCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slid_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slid_pkg::out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned VW   = slid_pkg::ValueW;

  logic signed [VW-1:0] vals [Capacity];
  logic [VW-1:0]        tails [Capacity];
  logic [Capacity-1:0]  lts, eqs;
  logic signed [VW-1:0] head, tail;

  logic [CntW-1:0]      count_q, count_d, remain_q, remain_d;
  logic                 busy_q, busy_d, desc_q, desc_d;
  logic                 out_valid_q, out_valid_d;
  slid_pkg::out_item_t  out_data_q, out_data_d;
  slid_pkg::cell_ctrl_t ctrl;

  logic load, accept, found, full;

  assign load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !load;
  assign accept = in_valid_i && !in_stall_o;
  assign found  = |eqs;
  assign full   = count_q == CntW'(Capacity);
  assign head   = vals[0];

  always_comb begin
    tail = '0;
    for (int i = 0; i < Capacity; i++) begin
      tail = tail | tails[i];
    end
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    slid_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .left_val_i  ((g == 0) ? tail : vals[(g == 0) ? 0 : g - 1]),
      .left_lt_i   ((g == 0) ? 1'b1 : lts[(g == 0) ? 0 : g - 1]),
      .right_val_i ((g == Capacity - 1) ? head : vals[(g == Capacity - 1) ? g : g + 1]),
      .head_i      (head),
      .val_o       (vals[g]),
      .lt_o        (lts[g]),
      .eq_o        (eqs[g]),
      .tail_o      (tails[g])
    );
  end

  always_comb begin
    count_d     = count_q;
    remain_d    = remain_q;
    busy_d      = busy_q;
    desc_d      = desc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ctrl.cmd    = slid_pkg::CMD_HOLD;
    ctrl.operand = in_data_i.value;

    if (busy_q && load) begin
      out_valid_d            = 1'b1;
      out_data_d.out_value   = desc_q ? tail : head;
      out_data_d.status      = slid_pkg::ST_OK;
      out_data_d.last_of_run = remain_q == CntW'(1);
      ctrl.cmd               = desc_q ? slid_pkg::CMD_ROT_RIGHT : slid_pkg::CMD_ROT_LEFT;
      remain_d               = remain_q - CntW'(1);
      busy_d                 = remain_q != CntW'(1);
    end else if (accept) begin
      out_data_d.out_value   = in_data_i.value;
      out_data_d.last_of_run = 1'b1;
      out_data_d.status      = slid_pkg::ST_OK;
      case (in_data_i.op)
        slid_pkg::OP_INSERT: begin
          out_valid_d = 1'b1;
          if (full) begin
            out_data_d.status = slid_pkg::ST_FULL;
          end else begin
            ctrl.cmd = slid_pkg::CMD_INSERT;
            count_d  = count_q + CntW'(1);
          end
        end
        slid_pkg::OP_DELETE: begin
          out_valid_d = 1'b1;
          if (found) begin
            ctrl.cmd = slid_pkg::CMD_DELETE;
            count_d  = count_q - CntW'(1);
          end else begin
            out_data_d.status = slid_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
          if (count_q == '0) begin
            out_valid_d          = 1'b1;
            out_data_d.out_value = '0;
            out_data_d.status    = slid_pkg::ST_EMPTY;
          end else begin
            busy_d   = 1'b1;
            remain_d = count_q;
            desc_d   = in_data_i.op == slid_pkg::OP_DUMP_DESC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      remain_q    <= '0;
      busy_q      <= 1'b0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      remain_q    <= remain_d;
      busy_q      <= busy_d;
      desc_q      <= desc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/slid_cell.sv =====
// one storage cell of the sorted chain
`timescale 1ns / 1ps

module slid_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                               clk_i,
  input  slid_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CntW-1:0]                    count_i,
  input  logic signed [slid_pkg::ValueW-1:0] left_val_i,
  input  logic                               left_lt_i,
  input  logic signed [slid_pkg::ValueW-1:0] right_val_i,
  input  logic signed [slid_pkg::ValueW-1:0] head_i,
  output logic signed [slid_pkg::ValueW-1:0] val_o,
  output logic                               lt_o,
  output logic                               eq_o,
  output logic [slid_pkg::ValueW-1:0]        tail_o
);

  logic signed [slid_pkg::ValueW-1:0] val_q, val_d;
  logic                               occ;
  logic                               is_tail;

  assign occ     = CntW'(Idx) < count_i;
  assign is_tail = occ && (CntW'(Idx + 1) == count_i);
  assign lt_o    = occ && (val_q < ctrl_i.operand);
  assign eq_o    = occ && (val_q == ctrl_i.operand);
  assign tail_o  = is_tail ? val_q : '0;
  assign val_o   = val_q;

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.cmd)
      slid_pkg::CMD_HOLD: val_d = val_q;
      slid_pkg::CMD_INSERT: begin
        if (!lt_o) begin
          val_d = left_lt_i ? ctrl_i.operand : left_val_i;
        end
      end
      slid_pkg::CMD_DELETE: begin
        if (occ && !lt_o) begin
          val_d = right_val_i;
        end
      end
      slid_pkg::CMD_ROT_LEFT: begin
        if (occ) begin
          val_d = is_tail ? head_i : right_val_i;
        end
      end
      slid_pkg::CMD_ROT_RIGHT: begin
        if (occ) begin
          val_d = left_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/core/slid_checker.sv =====
// port checks for the sorted list, bound to the top level
`timescale 1ns / 1ps

module slid_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input slid_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input slid_pkg::out_item_t out_data_o
);

  // a stalled result stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // no transfer in while the result register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

  // empty dump gives a single zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == slid_pkg::ST_EMPTY
      |-> out_data_o.last_of_run && out_data_o.out_value == '0)
    else $error("bad list empty result");

  // error results are always single
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == slid_pkg::ST_FULL ||
                    out_data_o.status == slid_pkg::ST_NOT_FOUND)
      |-> out_data_o.last_of_run)
    else $error("error result not last");

  // an insert or delete transfer gives a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.op == slid_pkg::OP_INSERT ||
                                  in_data_i.op == slid_pkg::OP_DELETE)
      |=> out_valid_o && out_data_o.last_of_run)
    else $error("missing insert or delete result");

endmodule

bind sorted_list_insert_delete_top slid_checker u_slid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
